/* hdl/rsst_pkg.sv */
`default_nettype none

package rsst_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned POS_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 42;
  localparam int unsigned LEN_W = 11;

  // Stream data widths, rounded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned MAX_ELEMENTS_DEF = 1024;

  typedef enum logic {
    OP_SET   = 1'b0,
    OP_QUERY = 1'b1
  } rsst_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic start;
    logic leaf;
    logic climb;
    logic q_left;
    logic q_right;
    logic out_load;
  } rsst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic upd_ok;
    logic qry_ok;
    logic at_root;
    logic l_lt_r;
  } rsst_stat_t;

endpackage

`default_nettype wire

/* hdl/rsst_dpath.sv */
`default_nettype none

module rsst_dpath #(
  parameter int unsigned MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rsst_pkg::rsst_cmd_t         cmd,
  output rsst_pkg::rsst_stat_t             stat,
  input  wire logic                        cfg_we,
  input  wire logic [rsst_pkg::LEN_W-1:0]  cfg_data,
  input  wire logic                        in_opcode,
  input  wire logic [rsst_pkg::POS_W-1:0]  in_position,
  input  wire logic [rsst_pkg::VAL_W-1:0]  in_new_value,
  input  wire logic [rsst_pkg::POS_W-1:0]  in_range_start,
  input  wire logic [rsst_pkg::POS_W-1:0]  in_range_end,
  output logic [rsst_pkg::SUM_W-1:0]       range_total
);
  import rsst_pkg::*;

  localparam int unsigned NODES = 2 * MAX_ELEMENTS;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned RW    = NW + 1;
  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LW    = (CW > LEN_W) ? CW : LEN_W;

  logic [SUM_W-1:0] mem [NODES];

  logic [LEN_W-1:0] array_length;
  logic [NW-1:0]    cnt;
  logic             pend;
  logic [NW-1:0]    node;
  logic [SUM_W-1:0] cur;
  logic [RW-1:0]    l;
  logic [RW-1:0]    r;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] rdata;

  logic [LW-1:0]    len;
  logic [LW-1:0]    len_m1;
  logic [LW-1:0]    hi_c;
  logic [NW-1:0]    parent;
  logic [SUM_W-1:0] sum;
  logic [RW-1:0]    r_dec;
  logic             wen;
  logic [NW-1:0]    waddr;
  logic [SUM_W-1:0] wdata;
  logic             ren;
  logic [NW-1:0]    raddr;

  // A length above the tree capacity acts as the capacity.
  assign len    = (LW'(array_length) > LW'(MAX_ELEMENTS)) ? LW'(MAX_ELEMENTS)
                                                          : LW'(array_length);
  assign len_m1 = len - LW'(1);
  assign hi_c   = (LW'(in_range_end) > len_m1) ? len_m1 : LW'(in_range_end);
  assign parent = node >> 1;
  assign sum    = cur + rdata;
  assign r_dec  = r - RW'(1);

  assign stat.clear_done = (cnt == NW'(NODES - 1));
  assign stat.is_query   = (in_opcode == OP_QUERY);
  assign stat.upd_ok     = (LW'(in_position) < len);
  assign stat.qry_ok     = (len != '0) && (LW'(in_range_start) <= hi_c);
  assign stat.at_root    = (parent == NW'(1));
  assign stat.l_lt_r     = (l < r);

  // Single write port: clearing pass, leaf write, or parent refresh.
  always_comb begin
    wen   = 1'b0;
    waddr = cnt;
    wdata = '0;
    priority if (cmd.clr_step) begin
      wen = 1'b1;
    end else if (cmd.leaf) begin
      wen   = 1'b1;
      waddr = node;
      wdata = cur;
    end else if (cmd.climb) begin
      wen   = 1'b1;
      waddr = parent;
      wdata = sum;
    end
  end

  // Single read port: sibling on the way up, or a covering node of a query.
  always_comb begin
    ren   = 1'b0;
    raddr = node ^ NW'(1);
    priority if (cmd.leaf) begin
      ren = 1'b1;
    end else if (cmd.climb) begin
      ren   = 1'b1;
      raddr = parent ^ NW'(1);
    end else if (cmd.q_left) begin
      ren   = 1'b1;
      raddr = NW'(l);
    end else if (cmd.q_right) begin
      ren   = 1'b1;
      raddr = NW'(r_dec);
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      array_length <= '0;
      cnt          <= '0;
      pend         <= 1'b0;
    end else begin
      if (cfg_we) begin
        array_length <= cfg_data;
      end
      if (cmd.clr_step) begin
        cnt <= cnt + NW'(1);
      end
      pend <= (cmd.q_left && l[0]) || (cmd.q_right && r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      node <= NW'(MAX_ELEMENTS) + NW'(in_position);
      cur  <= {{(SUM_W - VAL_W){in_new_value[VAL_W-1]}}, in_new_value};
      l    <= RW'(MAX_ELEMENTS) + RW'(in_range_start);
      r    <= RW'(MAX_ELEMENTS) + RW'(hi_c) + RW'(1);
    end else if (cmd.climb) begin
      node <= parent;
      cur  <= sum;
    end else if (cmd.q_left) begin
      if (l[0]) begin
        l <= l + RW'(1);
      end
    end else if (cmd.q_right) begin
      l <= l >> 1;
      r <= (r[0] ? r_dec : r) >> 1;
    end

    if (cmd.start) begin
      acc <= '0;
    end else if (pend) begin
      acc <= acc + rdata;
    end

    if (cmd.out_load) begin
      range_total <= acc;
    end
  end

endmodule

`default_nettype wire

/* hdl/rsst_ctrl.sv */
`default_nettype none

module rsst_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsst_pkg::rsst_cmd_t       cmd,
  input  wire rsst_pkg::rsst_stat_t stat
);
  import rsst_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_U_LEAF  = 7'b0000100,
    ST_U_CLIMB = 7'b0001000,
    ST_Q_LEFT  = 7'b0010000,
    ST_Q_RIGHT = 7'b0100000,
    ST_Q_FIN   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.start = 1'b1;
          if (stat.is_query) begin
            state_next = stat.qry_ok ? ST_Q_LEFT : ST_Q_FIN;
          end else if (stat.upd_ok) begin
            state_next = ST_U_LEAF;
          end
        end
      end
      ST_U_LEAF: begin
        cmd.leaf   = 1'b1;
        state_next = ST_U_CLIMB;
      end
      ST_U_CLIMB: begin
        cmd.climb = 1'b1;
        if (stat.at_root) begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_LEFT: begin
        if (stat.l_lt_r) begin
          cmd.q_left = 1'b1;
          state_next = ST_Q_RIGHT;
        end else begin
          state_next = ST_Q_FIN;
        end
      end
      ST_Q_RIGHT: begin
        cmd.q_right = 1'b1;
        state_next  = ST_Q_LEFT;
      end
      ST_Q_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    priority if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/range_sum_segment_tree.sv */
`default_nettype none

// Channel   Direction  Transfer when                   Payload
// s_axis    in         s_axis_tvalid & s_axis_tready   set or query item
// m_axis    out        m_axis_tvalid & m_axis_tready   range_total of a query
// cfg       in         cfg_valid & cfg_ready           array_length
//
// A set item inside the live length writes its leaf and then climbs one tree
// level per cycle, bounded by the single write port of the node memory; a set
// item outside the live length is dropped while the block stays idle.
// A query works up the tree level by level: each tree level takes a left step
// and a right step, as the node memory has one read port and both range
// ends may need a node at that level.
// After reset the node memory is cleared one node per cycle; s_axis_tready
// stays low meanwhile.
// A query result waits in the output register, and a stalled m_axis only
// holds up the next query in its final state.
module range_sum_segment_tree #(
  parameter int unsigned MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Input items.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [9:0] position, [41:10] new_value, [51:42] range_start,
  // [61:52] range_end, [63:62] zero.
  input  wire logic [rsst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] opcode.
  input  wire logic                             s_axis_tuser,
  // Query results.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [41:0] range_total, [47:42] zero.
  output logic [rsst_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // Configuration write.
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rsst_pkg::LEN_W-1:0]       cfg_data
);
  import rsst_pkg::*;

  localparam int unsigned VAL_LO   = POS_W;
  localparam int unsigned START_LO = VAL_LO + VAL_W;
  localparam int unsigned END_LO   = START_LO + POS_W;

  rsst_cmd_t        cmd;
  rsst_stat_t       stat;
  logic [SUM_W-1:0] range_total;

  // The length register can be written at any cycle; the host must do so only
  // while no item is in flight, which the block itself does not enforce.
  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = OUT_DATA_W'(range_total);

  rsst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rsst_dpath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .in_opcode      (s_axis_tuser),
    .in_position    (s_axis_tdata[POS_W-1:0]),
    .in_new_value   (s_axis_tdata[VAL_LO +: VAL_W]),
    .in_range_start (s_axis_tdata[START_LO +: POS_W]),
    .in_range_end   (s_axis_tdata[END_LO +: POS_W]),
    .range_total    (range_total)
  );

endmodule

`default_nettype wire

/* bench/range_sum_segment_tree_checker.sv */
`timescale 1ns / 1ps

// Watches the three channels of the range-sum tree, keeps its own copy of the
// element array and the length register, and compares each returned total
// with the oldest total still owed.
module range_sum_segment_tree_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  input  wire logic [rsst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic [rsst_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  wire logic                             cfg_valid,
  input  wire logic                             cfg_ready,
  input  wire logic [rsst_pkg::LEN_W-1:0]       cfg_data,
  output int                                    mismatch_count,
  output int                                    totals_outstanding
);
  import rsst_pkg::*;

  localparam int CAPACITY = MAX_ELEMENTS_DEF;

  logic signed [SUM_W-1:0] element_values [0:CAPACITY-1];
  logic [LEN_W-1:0]        length_reg;
  logic [SUM_W-1:0]        expected_totals [$];

  // Number of elements that take part, after the capacity limit.
  function automatic int live_length();
    return (length_reg > CAPACITY) ? CAPACITY : int'(length_reg);
  endfunction

  // Plain sum over the clipped range; the tree inside the block must agree.
  function automatic logic [SUM_W-1:0] clipped_range_total(input int lo, input int hi);
    logic signed [SUM_W-1:0] acc;
    int                      n;
    acc = '0;
    n   = live_length();
    if (n == 0)
      return '0;
    if (hi > n - 1)
      hi = n - 1;
    for (int i = lo; i <= hi; i++)
      acc += element_values[i];
    return acc;
  endfunction

  // Everything is sampled at the falling edge, clear of the edge at which the
  // transfer happens, so the order of events never matters.
  always @(negedge clk) begin
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  val;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [SUM_W-1:0]  want;
    logic [SUM_W-1:0]  got;
    if (rst) begin
      foreach (element_values[i])
        element_values[i] = '0;
      length_reg = '0;
      expected_totals.delete();
      mismatch_count     = 0;
      totals_outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        length_reg = cfg_data;

      if (s_axis_tvalid && s_axis_tready) begin
        pos = s_axis_tdata[9:0];
        val = s_axis_tdata[41:10];
        lo  = s_axis_tdata[51:42];
        hi  = s_axis_tdata[61:52];
        if (s_axis_tuser == OP_SET) begin
          if (int'(pos) < live_length())
            element_values[pos] = SUM_W'($signed(val));
        end else begin
          expected_totals.push_back(clipped_range_total(int'(lo), int'(hi)));
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[SUM_W-1:0];
        if (expected_totals.size() == 0) begin
          $display("%0t: range_total with no query pending: expected none, actual %0d",
                   $time, $signed(got));
          mismatch_count++;
        end else begin
          want = expected_totals.pop_front();
          if (got !== want) begin
            $display("%0t: range_total mismatch: expected %0d, actual %0d",
                     $time, $signed(want), $signed(got));
            mismatch_count++;
          end
        end
      end

      totals_outstanding = expected_totals.size();
    end
  end

endmodule

/* bench/range_sum_segment_tree_tb.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the range-sum segment tree. The checker beside the
// block does all prediction; this module only makes traffic, paces the two
// stream sides and decides the outcome.
module range_sum_segment_tree_tb;
  import rsst_pkg::*;

  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 190;
  // A set item has no result to wait for, so this much quiet time lets it
  // finish its climb before a write.
  localparam int SETTLE_CYCLES    = 30;
  localparam int DRAIN_LIMIT      = 50000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [9:0] position, [41:10] new_value, [51:42] range_start,
  // [61:52] range_end, [63:62] zero.
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // [0] opcode.
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [41:0] range_total, [47:42] zero.
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [LEN_W-1:0]       cfg_data = '0;

  int mismatch_count;
  int totals_outstanding;

  // Idle percentages for the sender and the receiver; the stimulus process
  // changes them from phase to phase.
  int snd_idle_pct = 25;
  int rcv_idle_pct = 69;
  // Live length as the stimulus sees it, used to aim positions and ranges.
  int live_len = 0;

  always #10 clk = ~clk;

  range_sum_segment_tree uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  range_sum_segment_tree_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .mismatch_count     (mismatch_count),
    .totals_outstanding (totals_outstanding)
  );

  // The result side stalls at random, one fresh decision per cycle.
  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

  // Offers one item and returns in the time step of its transfer, with
  // tvalid still high. The sender may idle first, at random.
  // The ready line is sampled at the falling edge, where it is stable.
  task automatic send_item(input rsst_op_t op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val, input logic [POS_W-1:0] lo,
                           input logic [POS_W-1:0] hi);
    logic seen;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, hi, lo, val, pos};
    do begin
      @(negedge clk);
      seen = s_axis_tready;
      @(posedge clk);
    end while (!seen);
  endtask

  // The fields a set item does not use carry random bits, and so do the
  // ones a query does not use.
  task automatic set_element(input int pos, input logic [VAL_W-1:0] val);
    send_item(OP_SET, POS_W'(pos), val, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic ask_range(input int lo, input int hi);
    send_item(OP_QUERY, POS_W'($urandom), $urandom, POS_W'(lo), POS_W'(hi));
  endtask

  // Writes array_length once the block has gone quiet: every owed total has
  // come back, and a trailing set item has had time to finish its climb.
  task automatic write_length(input int len);
    logic seen;
    s_axis_tvalid <= 1'b0;
    while (totals_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= LEN_W'(len);
    do begin
      @(negedge clk);
      seen = cfg_ready;
      @(posedge clk);
    end while (!seen);
    cfg_valid <= 1'b0;
    live_len = (len > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : len;
  endtask

  // One random item. Half are set items, half queries. Positions mostly land
  // inside the live length so the sums keep changing, with some anywhere in
  // the field so out-of-range sets happen too. Values lean toward the
  // extremes so the totals grow large in both directions.
  task automatic random_item();
    int                pos;
    int                lo;
    int                hi;
    logic [VAL_W-1:0]  val;
    if ($urandom_range(1) == 0) begin
      pos = ($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(live_len - 1);
      case ($urandom_range(7))
        0:       val = 32'h7FFF_FFFF;
        1:       val = 32'h8000_0000;
        default: val = $urandom;
      endcase
      set_element(pos, val);
    end else begin
      lo = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(live_len - 1);
      case ($urandom_range(7))
        0:       hi = 1023;
        1:       hi = $urandom_range(1023);
        2:       hi = (lo == 0) ? 0 : $urandom_range(lo - 1);
        default: hi = (lo >= live_len) ? lo : $urandom_range(lo, live_len - 1);
      endcase
      ask_range(lo, hi);
    end
  endtask

  initial begin
    int spins;
    int phase_len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Length zero: the set item must be dropped and the query must give 0.
    write_length(0);
    set_element(0, 32'd5);
    ask_range(0, 1023);

    // Full capacity: extreme values at both ends, bit patterns in the middle,
    // then whole, single, empty and inner ranges.
    write_length(MAX_ELEMENTS_DEF);
    set_element(0, 32'h7FFF_FFFF);
    set_element(1023, 32'h8000_0000);
    set_element(1, 32'hFFFF_FFFF);
    set_element(1022, 32'h7FFF_FFFF);
    set_element(682, 32'h5555_5555);
    set_element(341, 32'hAAAA_AAAA);
    ask_range(0, 1023);
    ask_range(0, 0);
    ask_range(1023, 1023);
    ask_range(5, 3);
    ask_range(1, 1022);
    ask_range(0, 1);

    // Length two: sets beyond it are dropped, query ends are clipped, and a
    // start past the clipped end gives 0.
    write_length(2);
    set_element(2, 32'h1234_5678);
    ask_range(0, 1023);
    ask_range(1, 1023);
    ask_range(2, 5);

    // A length above capacity acts as full capacity, and the elements hidden
    // a moment ago are visible again with their old values.
    write_length(2047);
    ask_range(0, 1023);
    set_element(1023, 32'd123);
    ask_range(1000, 1023);

    // Random phases. The first two pace with a slow receiver, the next two
    // with a slow sender, the last two run back to back.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       phase_len = MAX_ELEMENTS_DEF;
        1:       phase_len = $urandom_range(3, 1023);
        2:       phase_len = 1;
        3:       phase_len = 2047;
        4:       phase_len = $urandom_range(2, 64);
        default: phase_len = MAX_ELEMENTS_DEF;
      endcase
      write_length(phase_len);
      if (ph >= 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (ph >= 2) begin
        snd_idle_pct = 69;
        rcv_idle_pct = 25;
      end
      repeat (ITEMS_PER_PHASE) random_item();
    end
    s_axis_tvalid <= 1'b0;

    // Drain: wait for the last totals, bounded, then a little longer in case
    // something unexpected still comes out.
    spins = 0;
    while (totals_outstanding != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && totals_outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
